[hw/rtl/page_frame_allocator_lfu_defines.svh]
// Assertion macros shared by the checker.
`ifndef PAGE_FRAME_ALLOCATOR_LFU_DEFINES_SVH
`define PAGE_FRAME_ALLOCATOR_LFU_DEFINES_SVH
// Assert that a property holds on every clock edge outside reset.
`define PFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Assert that a property holds on every clock edge, reset included.
`define PFA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

[hw/rtl/pfa_lfu_pkg.sv]
package pfa_lfu_pkg;

  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE_PAGE = 2'd1;
  localparam logic [1:0] ACT_FREE_PROC = 2'd2;
  localparam logic [1:0] ACT_ACCESS = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  action;
    logic [19:0] amount;
    logic [3:0]  page_index;
    logic [15:0] process_id;
  } req_t;

  typedef struct packed {
    logic [3:0]  frame;
    logic [15:0] owner;
    logic [15:0] used_amount;
    logic        evicted;
    logic [15:0] evicted_owner;
    logic [4:0]  free_frames;
    logic [1:0]  status;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAP,
    S_SCAN,
    S_ASSIGN,
    S_SINGLE,
    S_PROC,
    S_COUNT,
    S_EMIT
  } state_t;

endpackage

[hw/rtl/pfa_lfu_ram.sv]
module pfa_lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[hw/rtl/page_frame_allocator_lfu.sv]
// Page frame allocator with least-frequently-used replacement.
// An allocate scans the frames once per page, a free process scans them once, and every request then
// counts the free frames in a further scan, one frame per cycle, before its beats are played out.
// Throughput: one request at a time; busy is high until the last beat, which cannot be stalled.
// Reset (rst, synchronous) empties all frames, zeroes counters, ids and sets page size 64.
module page_frame_allocator_lfu #(
  parameter int NUM_FRAMES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  pfa_lfu_pkg::req_t   req,
  output logic                done,
  output pfa_lfu_pkg::res_t   res,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);
  localparam int IW = $clog2(NUM_FRAMES);
  localparam int CW = $clog2(NUM_FRAMES + 1);

  pfa_lfu_pkg::state_t state, state_next;

  // Per-frame state lives in flip-flop rows: every row is needed by the scan and
  // the occupied flags reset at once. Rows are read at the scan index, the best frame and the page index.
  logic [NUM_FRAMES-1:0] occupied;
  logic [15:0] frame_used  [NUM_FRAMES];
  logic [15:0] frame_owner [NUM_FRAMES];
  logic [15:0] access_count[NUM_FRAMES];

  logic [15:0] page_size;
  logic [15:0] next_pid;
  pfa_lfu_pkg::req_t cur;
  logic [19:0] remaining;
  logic [IW:0] scan;
  logic [IW-1:0] best;
  logic found;
  logic [IW:0] npages;
  logic [CW-1:0] free_cnt;
  logic [IW:0] rd_ptr;

  // Beats are queued in a small memory and played out after the free count is known.
  logic q_we;
  logic [IW-1:0] q_waddr;
  logic [IW-1:0] q_raddr;
  pfa_lfu_pkg::res_t q_wdata, q_rdata;
  logic out_valid;
  logic q_hit;

  pfa_lfu_ram #(.WIDTH($bits(pfa_lfu_pkg::res_t)), .DEPTH(NUM_FRAMES)) u_queue (
    .clk  (clk),
    .we   (q_we),
    .waddr(q_waddr),
    .wdata(q_wdata),
    .raddr(q_raddr),
    .rdata(q_rdata)
  );

  logic [IW-1:0] si;
  logic [IW-1:0] pi;
  logic [31:0] cap;
  logic [19:0] use_amt;
  logic [15:0] bump_val;

  assign si = scan[IW-1:0];
  assign pi = IW'(cur.page_index);
  // One compare over the capacity product; page size times frame count fits 32 bits.
  assign cap = 32'(NUM_FRAMES) * 32'(page_size);
  assign use_amt = (remaining < 20'(page_size)) ? remaining : 20'(page_size);
  assign q_raddr = rd_ptr[IW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      pfa_lfu_pkg::S_IDLE: begin
        if (start) begin
          unique case (req.action)
            pfa_lfu_pkg::ACT_ALLOC:     state_next = pfa_lfu_pkg::S_CAP;
            pfa_lfu_pkg::ACT_FREE_PROC: state_next = pfa_lfu_pkg::S_PROC;
            default:                    state_next = pfa_lfu_pkg::S_SINGLE;
          endcase
        end
      end
      pfa_lfu_pkg::S_CAP: begin
        state_next = (32'(cur.amount) > cap) ? pfa_lfu_pkg::S_COUNT : pfa_lfu_pkg::S_SCAN;
      end
      pfa_lfu_pkg::S_SCAN: begin
        if (scan == (IW+1)'(NUM_FRAMES)) begin
          state_next = pfa_lfu_pkg::S_ASSIGN;
        end
      end
      pfa_lfu_pkg::S_ASSIGN: begin
        if (remaining == use_amt || npages == (IW+1)'(NUM_FRAMES - 1)) begin
          state_next = pfa_lfu_pkg::S_COUNT;
        end else begin
          state_next = pfa_lfu_pkg::S_SCAN;
        end
      end
      pfa_lfu_pkg::S_SINGLE: state_next = pfa_lfu_pkg::S_COUNT;
      pfa_lfu_pkg::S_PROC: begin
        if (scan == (IW+1)'(NUM_FRAMES)) begin
          state_next = pfa_lfu_pkg::S_COUNT;
        end
      end
      pfa_lfu_pkg::S_COUNT: begin
        if (scan == (IW+1)'(NUM_FRAMES)) begin
          state_next = pfa_lfu_pkg::S_EMIT;
        end
      end
      pfa_lfu_pkg::S_EMIT: begin
        if (out_valid && rd_ptr == npages) begin
          state_next = pfa_lfu_pkg::S_IDLE;
        end
      end
      default: state_next = pfa_lfu_pkg::S_IDLE;
    endcase
  end

  // Beat-queue write and counter bump value for the frame being touched.
  always_comb begin
    q_we = 1'b0;
    q_waddr = npages[IW-1:0];
    q_wdata = '0;
    bump_val = '0;
    unique case (state)
      pfa_lfu_pkg::S_CAP: begin
        if (32'(cur.amount) > cap) begin
          q_we = 1'b1;
          q_wdata.status = pfa_lfu_pkg::ST_TOO_LARGE;
        end
      end
      pfa_lfu_pkg::S_ASSIGN: begin
        q_we = 1'b1;
        q_wdata.frame = 4'(best);
        q_wdata.owner = next_pid;
        q_wdata.used_amount = use_amt[15:0];
        q_wdata.evicted = ~found;
        q_wdata.evicted_owner = found ? 16'd0 : frame_owner[best];
        bump_val = access_count[best];
      end
      pfa_lfu_pkg::S_SINGLE: begin
        q_we = 1'b1;
        q_wdata.frame = cur.page_index;
        if ({28'd0, cur.page_index} >= 32'(NUM_FRAMES)) begin
          q_wdata.status = pfa_lfu_pkg::ST_BAD_INDEX;
        end
        bump_val = access_count[pi];
      end
      pfa_lfu_pkg::S_PROC: begin
        if (scan != (IW+1)'(NUM_FRAMES)) begin
          q_we = occupied[si] && frame_owner[si] == cur.process_id;
          q_wdata.frame = 4'(si);
          bump_val = access_count[si];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfa_lfu_pkg::S_IDLE;
      occupied <= '0;
      page_size <= 16'd64;
      next_pid <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_used[i] <= '0;
        frame_owner[i] <= '0;
        access_count[i] <= '0;
      end
    end else begin
      state <= state_next;
      out_valid <= 1'b0;
      if (cfg_we) begin
        page_size <= cfg_wdata;
      end
      unique case (state)
        pfa_lfu_pkg::S_IDLE: begin
          if (start) begin
            cur <= req;
            remaining <= req.amount;
            npages <= '0;
            scan <= '0;
            found <= 1'b0;
            best <= '0;
          end
        end
        pfa_lfu_pkg::S_CAP: begin
          if (32'(cur.amount) > cap) begin
            npages <= (IW+1)'(1);
            scan <= '0;
            free_cnt <= '0;
          end
        end
        pfa_lfu_pkg::S_SCAN: begin
          // First free frame wins; otherwise track the strictly lower counter.
          if (scan != (IW+1)'(NUM_FRAMES)) begin
            if (!found) begin
              if (!occupied[si]) begin
                found <= 1'b1;
                best <= si;
              end else if (access_count[si] < access_count[best]) begin
                best <= si;
              end
            end
            scan <= scan + 1'b1;
          end
        end
        pfa_lfu_pkg::S_ASSIGN: begin
          occupied[best] <= 1'b1;
          frame_used[best] <= use_amt[15:0];
          frame_owner[best] <= next_pid;
          if (bump_val != pfa_lfu_pkg::CNT_MAX) begin
            access_count[best] <= bump_val + 1'b1;
          end
          remaining <= remaining - use_amt;
          npages <= npages + 1'b1;
          scan <= '0;
          found <= 1'b0;
          best <= '0;
          free_cnt <= '0;
          if (state_next == pfa_lfu_pkg::S_COUNT) begin
            next_pid <= next_pid + 1'b1;
          end
        end
        pfa_lfu_pkg::S_SINGLE: begin
          npages <= (IW+1)'(1);
          scan <= '0;
          free_cnt <= '0;
          if ({28'd0, cur.page_index} < 32'(NUM_FRAMES)) begin
            if (cur.action == pfa_lfu_pkg::ACT_FREE_PAGE) begin
              occupied[pi] <= 1'b0;
              frame_used[pi] <= '0;
              frame_owner[pi] <= '0;
            end
            if (bump_val != pfa_lfu_pkg::CNT_MAX) begin
              access_count[pi] <= bump_val + 1'b1;
            end
          end
        end
        pfa_lfu_pkg::S_PROC: begin
          if (scan != (IW+1)'(NUM_FRAMES)) begin
            if (q_we) begin
              occupied[si] <= 1'b0;
              frame_used[si] <= '0;
              frame_owner[si] <= '0;
              if (bump_val != pfa_lfu_pkg::CNT_MAX) begin
                access_count[si] <= bump_val + 1'b1;
              end
              npages <= npages + 1'b1;
            end
            scan <= scan + 1'b1;
          end else begin
            // No match still yields one zero beat.
            if (npages == '0) begin
              npages <= (IW+1)'(1);
            end
            scan <= '0;
            free_cnt <= '0;
          end
        end
        pfa_lfu_pkg::S_COUNT: begin
          if (scan != (IW+1)'(NUM_FRAMES)) begin
            free_cnt <= free_cnt + CW'(!occupied[si]);
            scan <= scan + 1'b1;
          end
          rd_ptr <= '0;
        end
        pfa_lfu_pkg::S_EMIT: begin
          // The queue read is registered: the beat comes in the cycle after its address.
          if (rd_ptr != npages) begin
            out_valid <= 1'b1;
            rd_ptr <= rd_ptr + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // A beat is on the ports while the entry read in the previous cycle is valid.
  assign done = out_valid;

  // The zero beat of a free process with no match is not queued; the output is forced to zero instead.
  always_comb begin
    res = q_rdata;
    if (state == pfa_lfu_pkg::S_EMIT && cur.action == pfa_lfu_pkg::ACT_FREE_PROC
        && rd_ptr == (IW+1)'(1) && npages == (IW+1)'(1) && !q_hit) begin
      res = '0;
    end
    res.free_frames = 5'(free_cnt);
    res.last = (rd_ptr == npages);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_hit <= 1'b0;
    end else if (state == pfa_lfu_pkg::S_IDLE) begin
      q_hit <= 1'b0;
    end else if (q_we) begin
      q_hit <= 1'b1;
    end
  end

  assign busy = (state != pfa_lfu_pkg::S_IDLE);
endmodule

[hw/rtl/pfa_lfu_checker.sv]
`include "page_frame_allocator_lfu_defines.svh"
module pfa_lfu_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input pfa_lfu_pkg::res_t res
);
  `PFA_ASSERT(a_busy_after_start, (start && !busy) |=> busy, "start not taken")
  `PFA_ASSERT(a_done_when_busy, done |-> busy, "beat while idle")
  `PFA_ASSERT(a_idle_after_last, (done && res.last) |=> !done, "beat after last")
  `PFA_ASSERT(a_free_range, done |-> (res.free_frames <= 5'd16), "free count out of range")
  `PFA_ASSERT_ALWAYS(a_idle_out_of_reset, rst |=> (!busy && !done), "not idle after reset")
endmodule

bind page_frame_allocator_lfu pfa_lfu_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .res(res)
);

[tb/tb_page_frame_allocator_lfu.sv]
`timescale 1ns / 100ps

// Scoreboard: keeps a behavioural copy of the frame table and the queue of
// beats the allocator is expected to produce.
class frame_table_sb;
  localparam int NF = 16;
  logic [15:0] page_size;
  bit          occ[NF];
  logic [15:0] used[NF];
  logic [15:0] owner[NF];
  logic [15:0] hits[NF];
  logic [15:0] next_pid;
  pfa_lfu_pkg::res_t pending_beats[$];
  int          mismatches;

  function new();
    page_size = 16'd64;
    next_pid = '0;
    mismatches = 0;
    for (int i = 0; i < NF; i++) begin
      occ[i] = 0; used[i] = '0; owner[i] = '0; hits[i] = '0;
    end
  endfunction

  function void bump(int f);
    if (hits[f] != pfa_lfu_pkg::CNT_MAX) hits[f] = hits[f] + 16'd1;
  endfunction

  function void release_frame(int f);
    occ[f] = 0; used[f] = '0; owner[f] = '0;
    bump(f);
  endfunction

  function pfa_lfu_pkg::res_t beat(int f, logic [15:0] own, logic [15:0] u, bit ev,
                                   logic [15:0] evo, logic [1:0] st);
    pfa_lfu_pkg::res_t r;
    r = '0;
    r.frame = f[3:0]; r.owner = own; r.used_amount = u;
    r.evicted = ev; r.evicted_owner = evo; r.status = st;
    return r;
  endfunction

  // Notes an accepted request and queues the beats it should produce.
  function void note_request(pfa_lfu_pkg::req_t q);
    pfa_lfu_pkg::res_t beats[$];
    logic [31:0] cap, remaining, u;
    int          f, nfree;
    bit          found, ev;
    logic [15:0] evo;
    cap = NF * page_size;
    case (q.action)
      pfa_lfu_pkg::ACT_ALLOC: begin
        if (32'(q.amount) > cap) begin
          beats.push_back(beat(0, '0, '0, 0, '0, pfa_lfu_pkg::ST_TOO_LARGE));
        end else begin
          remaining = 32'(q.amount);
          do begin
            found = 0; f = 0; ev = 0; evo = '0;
            for (int i = 0; i < NF; i++)
              if (!found && !occ[i]) begin f = i; found = 1; end
            if (!found) begin
              for (int i = 1; i < NF; i++)
                if (hits[i] < hits[f]) f = i;
              ev = 1; evo = owner[f];
            end
            u = (remaining < 32'(page_size)) ? remaining : 32'(page_size);
            occ[f] = 1; used[f] = u[15:0]; owner[f] = next_pid;
            bump(f);
            remaining = remaining - u;
            beats.push_back(beat(f, next_pid, u[15:0], ev, evo, pfa_lfu_pkg::ST_OK));
          end while (remaining != 0 && beats.size() < NF);
          next_pid = next_pid + 16'd1;
        end
      end
      pfa_lfu_pkg::ACT_FREE_PAGE, pfa_lfu_pkg::ACT_ACCESS: begin
        if (q.action == pfa_lfu_pkg::ACT_FREE_PAGE) release_frame(int'(q.page_index));
        else bump(int'(q.page_index));
        beats.push_back(beat(int'(q.page_index), '0, '0, 0, '0, pfa_lfu_pkg::ST_OK));
      end
      default: begin
        for (int i = 0; i < NF; i++)
          if (occ[i] && owner[i] == q.process_id) begin
            release_frame(i);
            beats.push_back(beat(i, '0, '0, 0, '0, pfa_lfu_pkg::ST_OK));
          end
        if (beats.size() == 0) beats.push_back(beat(0, '0, '0, 0, '0, pfa_lfu_pkg::ST_OK));
      end
    endcase
    nfree = 0;
    for (int i = 0; i < NF; i++) if (!occ[i]) nfree++;
    foreach (beats[k]) begin
      beats[k].free_frames = nfree[4:0];
      beats[k].last = (k == beats.size() - 1);
      pending_beats.push_back(beats[k]);
    end
  endfunction

  // Checks one result beat against the oldest expectation.
  function void check_beat(pfa_lfu_pkg::res_t got);
    pfa_lfu_pkg::res_t want;
    if (pending_beats.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected beat %p", got);
      return;
    end
    want = pending_beats.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
    end
  endfunction
endclass

module tb_page_frame_allocator_lfu;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  pfa_lfu_pkg::req_t req = '0;
  logic        done;
  pfa_lfu_pkg::res_t res;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  frame_table_sb sb = new();
  int          idle_cycles = 0;

  always #5 clk = ~clk;

  page_frame_allocator_lfu dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .res(res), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Results cannot be held off, so every strobed beat is checked at the
  // edge that closes its cycle.
  always @(posedge clk) begin
    if (!rst && done) sb.check_beat(res);
  end

  // The watchdog restarts whenever a request or a result beat is accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL page_frame_allocator_lfu");
        $finish;
      end
    end
  end

  // Presents one request and holds it until the block takes it. Start stays
  // high between back-to-back requests, so it is never dropped and raised in
  // the same step.
  task automatic send_request(pfa_lfu_pkg::req_t q);
    req <= q;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(q);
  endtask

  task automatic pause_sender(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Waits until every expected beat has come and the block is no longer busy,
  // then lets the clock run on before the next phase.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_beats.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_page_size(logic [15:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.page_size = v;
    @(posedge clk);
  endtask

  function automatic pfa_lfu_pkg::req_t make_req(logic [1:0] act, logic [19:0] amt,
                                                 logic [3:0] idx, logic [15:0] pid);
    pfa_lfu_pkg::req_t q;
    q.action = act; q.amount = amt; q.page_index = idx; q.process_id = pid;
    return q;
  endfunction

  // Mostly sensible traffic: allocations sized a few pages, frees and
  // accesses spread over the table, frees of recently issued ids. The rest
  // is noise over the full field ranges.
  function automatic pfa_lfu_pkg::req_t random_req();
    pfa_lfu_pkg::req_t q;
    int          pick;
    logic [31:0] cap;
    q = pfa_lfu_pkg::req_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    cap = 16 * sb.page_size;
    if (pick < 35) begin
      q.action = pfa_lfu_pkg::ACT_ALLOC;
      if ($urandom_range(0, 9) == 0) q.amount = 20'($urandom);
      else q.amount = 20'($urandom_range(0, 4 * sb.page_size));
      if ($urandom_range(0, 19) == 0) q.amount = cap[19:0];
    end else if (pick < 55) begin
      q.action = pfa_lfu_pkg::ACT_ACCESS;
    end else if (pick < 70) begin
      q.action = pfa_lfu_pkg::ACT_FREE_PAGE;
    end else if (pick < 90) begin
      q.action = pfa_lfu_pkg::ACT_FREE_PROC;
      q.process_id = sb.next_pid - 16'($urandom_range(1, 6));
    end else begin
      q.action = pfa_lfu_pkg::ACT_FREE_PROC;
    end
    return q;
  endfunction

  task automatic random_phase(int count);
    int burst;
    while (count > 0) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && count > 0) begin
        send_request(random_req());
        burst--; count--;
      end
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 40));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset page size of 64.
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'd0, '0, '0));          // zero amount
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'd1025, '0, '0));       // too large
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'd1024, '0, '0));       // whole table
    send_request(make_req(pfa_lfu_pkg::ACT_ACCESS, '0, 4'd0, '0));
    send_request(make_req(pfa_lfu_pkg::ACT_ACCESS, '0, 4'd15, '0));
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'd130, '0, '0));        // evicts
    send_request(make_req(pfa_lfu_pkg::ACT_FREE_PAGE, '0, 4'd15, '0));
    send_request(make_req(pfa_lfu_pkg::ACT_FREE_PAGE, '0, 4'd15, '0));      // already free
    send_request(make_req(pfa_lfu_pkg::ACT_ACCESS, '0, 4'd15, '0));         // free frame
    send_request(make_req(pfa_lfu_pkg::ACT_FREE_PROC, '0, '0, 16'd1));
    send_request(make_req(pfa_lfu_pkg::ACT_FREE_PROC, '0, '0, 16'd2));
    send_request(make_req(pfa_lfu_pkg::ACT_FREE_PROC, '0, '0, 16'hFFFF));   // no match
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'hFFFFF, '0, '0));
    drain();

    // Page size of one: tiny capacity, own pages get evicted within a request.
    set_page_size(16'd1);
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'd16, '0, '0));
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'd3, '0, '0));
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'd17, '0, '0));
    random_phase(100);
    drain();

    // Page size of zero: only zero amounts fit.
    set_page_size(16'd0);
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'd0, '0, '0));
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'd1, '0, '0));
    random_phase(40);
    drain();

    // Largest page size: capacity just below the top of the amount field's range.
    set_page_size(16'hFFFF);
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'hFFFFF, '0, '0));
    send_request(make_req(pfa_lfu_pkg::ACT_ALLOC, 20'd65536, '0, '0));
    random_phase(80);
    drain();

    set_page_size(16'($urandom_range(2, 300)));
    random_phase(150);
    drain();

    set_page_size(16'd64);
    random_phase(130);
    drain();

    if (sb.mismatches == 0 && sb.pending_beats.size() == 0) begin
      $display("PASS page_frame_allocator_lfu");
    end else begin
      $display("FAIL page_frame_allocator_lfu");
    end
    $finish;
  end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pfa_lfu_pkg.sv
hw/rtl/pfa_lfu_ram.sv
hw/rtl/page_frame_allocator_lfu.sv
hw/rtl/pfa_lfu_checker.sv
tb/tb_page_frame_allocator_lfu.sv
